@@ hdl/assert_macros.svh @@
// assertion macros used by the frame table back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PFTF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("frame table assertion failed");
`define PFTF_ASSERT_NEXT(label, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("frame table assertion failed");
`else
`define PFTF_ASSERT(label, prop)
`define PFTF_ASSERT_NEXT(label, cond, nxt)
`endif
`endif

@@ hdl/pftf_pkg.sv @@
// shared types and constants of the frame table
package pftf_pkg;
    localparam int NUM_FRAMES_DEF = 64;
    localparam int PID_W   = 16;
    localparam int ADDR_W  = 31;
    localparam int PAGE_W  = 31;
    localparam int FIDX_W  = 6;
    localparam int FREED_W = 7;
    localparam int USAGE_W = 23;
    localparam int TALLY_W = 32;
    localparam int FC_W    = 7;
    localparam int FB_W    = 17;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 120;
    localparam logic [FC_W-1:0] FC_RESET = 7'd64;
    localparam logic [FB_W-1:0] FB_RESET = 17'd16;
    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_FRAME_BYTES = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOOKUP  = 2'd0,
        KIND_FAULT   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_USAGE   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [PID_W-1:0]   pid;
        logic [PAGE_W-1:0]  page;
    } req_t;

    // packed so that hit sits in the lowest bit
    typedef struct packed {
        logic [TALLY_W-1:0] total;
        logic [USAGE_W-1:0] usage;
        logic [FREED_W-1:0] freed;
        logic [PAGE_W-1:0]  vpage;
        logic [PID_W-1:0]   vpid;
        logic               evicted;
        logic               no_frame;
        logic [FIDX_W-1:0]  fidx;
        logic               hit;
    } res_t;

    typedef struct packed {
        logic              rebuild;
        logic [FC_W-1:0]   frame_count;
        logic [FB_W-1:0]   frame_bytes;
    } cfg_t;
endpackage

@@ hdl/pftf_front.sv @@
// front end: accepts requests and turns the address of lookup and fault requests into a page number
module pftf_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pftf_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic [pftf_pkg::FB_W-1:0]      frame_bytes,
    output logic                           q_valid,
    input  logic                           q_ready,
    output pftf_pkg::req_t                 q_req
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;
    pftf_pkg::req_t req_reg, req_next;
    logic [pftf_pkg::FB_W-1:0]   rem_reg, rem_next;
    logic [pftf_pkg::ADDR_W-1:0] quo_reg, quo_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [pftf_pkg::FB_W-1:0] dvs;
    logic [pftf_pkg::FB_W:0]   sh;
    logic                      qbit;

    assign dvs = (frame_bytes == '0) ? pftf_pkg::FB_W'(1) : frame_bytes;
    assign sh = {rem_reg, quo_reg[pftf_pkg::ADDR_W-1]};
    assign qbit = (sh >= {1'b0, dvs});
    assign s_tready = (state_reg == F_IDLE);
    assign q_valid = (state_reg == F_PUSH);
    assign q_req = req_reg;

    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next.kind = pftf_pkg::kind_t'(s_tuser);
                    req_next.pid = s_tdata[15:0];
                    req_next.page = '0;
                    rem_next = '0;
                    quo_next = s_tdata[46:16];
                    cnt_next = '0;
                    if (pftf_pkg::kind_t'(s_tuser) == pftf_pkg::KIND_LOOKUP ||
                        pftf_pkg::kind_t'(s_tuser) == pftf_pkg::KIND_FAULT)
                        state_next = F_DIV;
                    else
                        state_next = F_PUSH;
                end
            end
            F_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next = qbit ? pftf_pkg::FB_W'(sh - {1'b0, dvs}) : sh[pftf_pkg::FB_W-1:0];
                quo_next = {quo_reg[pftf_pkg::ADDR_W-2:0], qbit};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(pftf_pkg::ADDR_W - 1))
                begin
                    req_next.page = {quo_reg[pftf_pkg::ADDR_W-2:0], qbit};
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (q_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end
endmodule

@@ hdl/pftf_queue.sv @@
// two-entry request queue between front and back
module pftf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pftf_pkg::req_t in_req,
    output logic           out_valid,
    input  logic           out_ready,
    output pftf_pkg::req_t out_req
);
    pftf_pkg::req_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_req = slot_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_req;
    end
endmodule

@@ hdl/pftf_back.sv @@
// back end: frame table, free stack and fifo age order
`include "assert_macros.svh"
module pftf_back #(
    parameter int NUM_FRAMES = pftf_pkg::NUM_FRAMES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pftf_pkg::cfg_t cfg,
    input  logic           q_valid,
    output logic           q_ready,
    input  pftf_pkg::req_t q_req,
    output logic           res_valid,
    input  logic           res_ready,
    output pftf_pkg::res_t res
);
    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int CMP_W = (CNT_W > pftf_pkg::FC_W) ? CNT_W : pftf_pkg::FC_W;
    localparam int TW    = pftf_pkg::TALLY_W;
    // frames in use with the reset configuration
    localparam int RST_FRAMES = (int'(pftf_pkg::FC_RESET) > NUM_FRAMES) ?
                                NUM_FRAMES : int'(pftf_pkg::FC_RESET);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POP  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_LOAD = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;
    pftf_pkg::req_t cur_reg, cur_next;
    pftf_pkg::res_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;

    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] free_depth_reg, free_depth_next;
    logic [CNT_W-1:0] min_depth_reg, min_depth_next;
    logic [TW-1:0] seq_reg, seq_next;
    logic [TW-1:0] tally_reg, tally_next;

    logic [CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TW-1:0] best_age_reg, best_age_next;
    logic [pftf_pkg::PID_W-1:0] vpid_reg, vpid_next;
    logic [pftf_pkg::PAGE_W-1:0] vpage_reg, vpage_next;
    logic evict_reg, evict_next;
    logic [IDX_W-1:0] load_idx_reg, load_idx_next;

    // entry memories
    logic [pftf_pkg::PID_W-1:0]  ent_pid_mem   [NUM_FRAMES];
    logic [pftf_pkg::PAGE_W-1:0] ent_page_mem  [NUM_FRAMES];
    logic [TW-1:0]               ent_stamp_mem [NUM_FRAMES];
    logic [pftf_pkg::PID_W-1:0]  rd_pid_reg;
    logic [pftf_pkg::PAGE_W-1:0] rd_page_reg;
    logic [TW-1:0]               rd_stamp_reg;
    logic                        ent_we;

    // free stack memory
    logic [IDX_W-1:0] stack_mem [NUM_FRAMES];
    logic [IDX_W-1:0] stack_rd_reg;
    logic             stack_we;
    logic [CNT_W-1:0] pop_pos;

    logic [CMP_W-1:0] fc_w;
    logic [CNT_W-1:0] n_frames;
    logic [TW-1:0]    age;
    logic             entry_live, pid_match;
    logic [pftf_pkg::FB_W+CNT_W-1:0] usage_prod;

    assign fc_w = CMP_W'(cfg.frame_count);
    assign n_frames = (cfg.frame_bytes == '0) ? '0 :
                      (fc_w > CMP_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : CNT_W'(fc_w);
    assign pop_pos = free_depth_reg - CNT_W'(1);
    assign age = seq_reg - rd_stamp_reg;
    assign entry_live = valid_reg[rd_idx_reg];
    assign pid_match = (rd_pid_reg == cur_reg.pid);
    assign usage_prod = count_reg * cfg.frame_bytes;

    assign q_ready = (state_reg == ST_IDLE) && !res_valid_reg && !cfg.rebuild;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg;
        valid_next = valid_reg;
        free_depth_next = free_depth_reg;
        min_depth_next = min_depth_reg;
        seq_next = seq_reg;
        tally_next = tally_reg;
        scan_addr_next = scan_addr_reg;
        rd_vld_next = 1'b0;
        found_next = found_reg;
        found_idx_next = found_idx_reg;
        count_next = count_reg;
        best_age_next = best_age_reg;
        vpid_next = vpid_reg;
        vpage_next = vpage_reg;
        evict_next = evict_reg;
        load_idx_next = load_idx_reg;
        ent_we = 1'b0;
        stack_we = 1'b0;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg.rebuild)
                begin
                    valid_next = '0;
                    free_depth_next = n_frames;
                    min_depth_next = n_frames;
                end
                else if (q_valid && q_ready)
                begin
                    cur_next = q_req;
                    scan_addr_next = '0;
                    found_next = 1'b0;
                    found_idx_next = '0;
                    count_next = '0;
                    best_age_next = '0;
                    evict_next = 1'b0;
                    if (q_req.kind == pftf_pkg::KIND_FAULT && free_depth_reg != '0)
                        state_next = ST_POP;
                    else if (q_req.kind == pftf_pkg::KIND_FAULT && valid_reg == '0)
                    begin
                        res_next = '0;
                        res_next.no_frame = 1'b1;
                        res_next.total = tally_reg;
                        res_valid_next = 1'b1;
                    end
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_POP:
            begin
                // positions below the low-water mark still hold their initial frame
                if (pop_pos < min_depth_reg)
                    load_idx_next = IDX_W'(n_frames - CNT_W'(1) - pop_pos);
                else
                    load_idx_next = stack_rd_reg;
                free_depth_next = pop_pos;
                if (pop_pos < min_depth_reg)
                    min_depth_next = pop_pos;
                state_next = ST_LOAD;
            end
            ST_SCAN:
            begin
                if (scan_addr_reg < n_frames)
                begin
                    rd_vld_next = 1'b1;
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    case (cur_reg.kind)
                        pftf_pkg::KIND_LOOKUP:
                        begin
                            if (entry_live && pid_match && rd_page_reg == cur_reg.page &&
                                !found_reg)
                            begin
                                found_next = 1'b1;
                                found_idx_next = rd_idx_reg;
                            end
                        end
                        pftf_pkg::KIND_RELEASE:
                        begin
                            if (entry_live && pid_match)
                            begin
                                valid_next[rd_idx_reg] = 1'b0;
                                stack_we = 1'b1;
                                free_depth_next = free_depth_reg + CNT_W'(1);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        pftf_pkg::KIND_USAGE:
                        begin
                            if (entry_live && pid_match)
                                count_next = count_reg + CNT_W'(1);
                        end
                        default:
                        begin
                            // oldest loaded frame has the largest age
                            if (entry_live && (!found_reg || age > best_age_reg))
                            begin
                                found_next = 1'b1;
                                best_age_next = age;
                                found_idx_next = rd_idx_reg;
                                vpid_next = rd_pid_reg;
                                vpage_next = rd_page_reg;
                            end
                        end
                    endcase
                end
                else if (scan_addr_reg >= n_frames)
                begin
                    res_next = '0;
                    res_next.total = tally_reg;
                    state_next = ST_IDLE;
                    case (cur_reg.kind)
                        pftf_pkg::KIND_LOOKUP:
                        begin
                            res_next.hit = found_reg;
                            res_next.fidx = found_reg ? pftf_pkg::FIDX_W'(found_idx_reg) : '0;
                            res_valid_next = 1'b1;
                        end
                        pftf_pkg::KIND_RELEASE:
                        begin
                            res_next.freed = pftf_pkg::FREED_W'(count_reg);
                            res_valid_next = 1'b1;
                        end
                        pftf_pkg::KIND_USAGE:
                        begin
                            res_next.usage = pftf_pkg::USAGE_W'(usage_prod);
                            res_valid_next = 1'b1;
                        end
                        default:
                        begin
                            evict_next = 1'b1;
                            load_idx_next = found_idx_reg;
                            tally_next = tally_reg + TW'(1);
                            state_next = ST_LOAD;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                ent_we = 1'b1;
                valid_next[load_idx_reg] = 1'b1;
                seq_next = seq_reg + TW'(1);
                res_next = '0;
                res_next.fidx = pftf_pkg::FIDX_W'(load_idx_reg);
                res_next.evicted = evict_reg;
                res_next.vpid = evict_reg ? vpid_reg : '0;
                res_next.vpage = evict_reg ? vpage_reg : '0;
                res_next.total = tally_reg;
                res_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_valid_reg <= 1'b0;
            valid_reg <= '0;
            free_depth_reg <= CNT_W'(RST_FRAMES);
            min_depth_reg <= CNT_W'(RST_FRAMES);
            seq_reg <= '0;
            tally_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
            valid_reg <= valid_next;
            free_depth_reg <= free_depth_next;
            min_depth_reg <= min_depth_next;
            seq_reg <= seq_next;
            tally_reg <= tally_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        scan_addr_reg <= scan_addr_next;
        found_reg <= found_next;
        found_idx_reg <= found_idx_next;
        count_reg <= count_next;
        best_age_reg <= best_age_next;
        vpid_reg <= vpid_next;
        vpage_reg <= vpage_next;
        evict_reg <= evict_next;
        load_idx_reg <= load_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_pid_mem[load_idx_reg] <= cur_reg.pid;
            ent_page_mem[load_idx_reg] <= cur_reg.page;
            ent_stamp_mem[load_idx_reg] <= seq_reg;
        end
        rd_pid_reg <= ent_pid_mem[scan_addr_reg[IDX_W-1:0]];
        rd_page_reg <= ent_page_mem[scan_addr_reg[IDX_W-1:0]];
        rd_stamp_reg <= ent_stamp_mem[scan_addr_reg[IDX_W-1:0]];
        rd_idx_reg <= scan_addr_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[free_depth_reg[IDX_W-1:0]] <= rd_idx_reg;
        stack_rd_reg <= stack_mem[pop_pos[IDX_W-1:0]];
    end

    `PFTF_ASSERT(a_depth_max, free_depth_reg <= CNT_W'(NUM_FRAMES))
    `PFTF_ASSERT(a_low_water, min_depth_reg <= free_depth_reg)
    `PFTF_ASSERT_NEXT(a_load_result, state_reg == ST_LOAD, res_valid_reg)
endmodule

@@ hdl/page_frame_table_fifo_replacement_core.sv @@
// top level of the demand-paging frame table with fifo replacement
// Each request produces exactly one result. The front end divides the
// address of lookup and fault requests by frame_bytes with a restoring
// divider, one bit per cycle; release and usage requests skip the divider.
// A two-entry queue then hands the request to the back end, which walks the
// frame table one entry per cycle through its memory read port. A fault that
// finds a free frame takes it without a scan. The back end takes the next
// request in the cycle after its result transfer, and the front end works
// on the next request while the back end scans. A configuration write
// rebuilds the table if it reaches the back end while that is idle, and
// keeps the eviction count.
module page_frame_table_fifo_replacement_core #(
    parameter int NUM_FRAMES = pftf_pkg::NUM_FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pftf_pkg::IN_DATA_W-1:0]  s_tdata,  // pid, address
    input  logic [1:0]                      s_tuser,  // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, frame_index, no_frame, evicted, victim_pid, victim_page,
    // freed_frames, usage_bytes, paged_out_total
    output logic [pftf_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    logic [pftf_pkg::FC_W-1:0] frame_count_reg;
    logic [pftf_pkg::FB_W-1:0] frame_bytes_reg;
    logic                      rebuild_reg;
    logic                      wr_en;
    pftf_pkg::cfg_t            cfg;
    logic                      q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    pftf_pkg::req_t            q_in_req, q_out_req;
    pftf_pkg::res_t            res;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == pftf_pkg::REG_FRAME_BYTES) ?
                    32'(frame_bytes_reg) : 32'(frame_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= pftf_pkg::FC_RESET;
            frame_bytes_reg <= pftf_pkg::FB_RESET;
            rebuild_reg <= 1'b0;
        end
        else
        begin
            rebuild_reg <= wr_en;
            if (wr_en && paddr[2] == pftf_pkg::REG_FRAME_COUNT)
                frame_count_reg <= pwdata[pftf_pkg::FC_W-1:0];
            if (wr_en && paddr[2] == pftf_pkg::REG_FRAME_BYTES)
                frame_bytes_reg <= pwdata[pftf_pkg::FB_W-1:0];
        end
    end

    assign cfg.rebuild = rebuild_reg;
    assign cfg.frame_count = frame_count_reg;
    assign cfg.frame_bytes = frame_bytes_reg;

    pftf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .frame_bytes (frame_bytes_reg),
        .q_valid     (q_in_valid),
        .q_ready     (q_in_ready),
        .q_req       (q_in_req)
    );

    pftf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_req    (q_in_req),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_req   (q_out_req)
    );

    pftf_back #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_out_valid),
        .q_ready   (q_out_ready),
        .q_req     (q_out_req),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {2'b00, res};
endmodule
